### design/apgt_pkg.sv
package apgt_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int DivSteps  = DataWidth + FracBits;

    localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
    localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};
    localparam logic signed [DataWidth-1:0] COne   = DataWidth'(64'sd1 << FracBits);
    localparam logic signed [DataWidth-1:0] CTwo   = DataWidth'(64'sd2 << FracBits);
    localparam logic signed [DataWidth-1:0] CFifty = DataWidth'(64'sd50 << FracBits);
    localparam logic signed [DataWidth-1:0] CHund  = DataWidth'(64'sd100 << FracBits);
    localparam logic signed [DataWidth-1:0] CC1 =
        DataWidth'((64'd313 * (64'd1 << FracBits) + 64'd5000) / 64'd10000);
    localparam logic signed [DataWidth-1:0] CC2 =
        DataWidth'((64'd553 * (64'd1 << FracBits) + 64'd5000) / 64'd10000);

    typedef logic signed [DataWidth-1:0] t_word;

    // alu operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic  start;
        t_op   op;
        t_word a;
        t_word b;
    } t_alu_req;

    typedef struct packed {
        logic  done;
        t_word y;
    } t_alu_rsp;

    localparam int NumCfg = 7;
    localparam logic [2:0] REG_SP    = 3'd0;
    localparam logic [2:0] REG_WN    = 3'd1;
    localparam logic [2:0] REG_ZETA  = 3'd2;
    localparam logic [2:0] REG_GP    = 3'd3;
    localparam logic [2:0] REG_GI    = 3'd4;
    localparam logic [2:0] REG_GD    = 3'd5;
    localparam logic [2:0] REG_TAU   = 3'd6;

endpackage

### design/adaptive_pid_gain_tuner_top.sv
// each request runs 43 micro-ops in turn on one alu; add, sub and mul
// results are registered, and each of the three divides yields 48
// quotient bits, one bit a cycle, unless the divisor is zero (saturated result)
// no new request is taken while the micro-ops run; input ready only while idle
// a result waits in the output register; the next request is taken meanwhile
// reset (sync, active low) clears the config and model state, wn and zeta to 1.0, rest to zero
module adaptive_pid_gain_tuner_top import apgt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // measured_speed [31:0], interval [62:32], zero [63]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reference_speed [31:0], tracking_error [63:32], prop_gain [86:64],
    // integ_gain [118:87], deriv_gain [150:119], zero [151]
    output logic [151:0] m_axis_tdata
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    // sequence of micro-ops, each reads two operands and writes one temp/state; the last also saves err
    localparam int NumOps = 43;
    localparam int PcW = $clog2(NumOps);

    t_state r_state, n_state;
    logic [PcW-1:0] r_pc;

    t_word r_sp, r_wn, r_zeta, r_gp, r_gi, r_gd, r_tau;
    t_word r_spd, r_acc, r_kp, r_ki, r_kd, r_int, r_lerr, r_fd;
    t_word r_meas, r_dt;
    t_word r_t0, r_t1, r_t2, r_err, r_dq, r_fq;

    logic        r_ovalid;
    logic [151:0] r_odata;

    t_alu_req w_req;
    t_alu_rsp w_rsp;
    logic     r_issued;

    apgt_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // program: op, operand a, operand b (temps t0..t2)
    always_comb begin
        w_req.start = (r_state == S_RUN) && !r_issued;
        w_req.op = OP_MUL;
        w_req.a  = '0;
        w_req.b  = '0;
        unique case (r_pc)
            6'd0:  begin w_req.a = r_wn;   w_req.b = r_wn; end          // t0 = wn2
            6'd1:  begin w_req.a = r_t0;   w_req.b = r_sp; end          // t1
            6'd2:  begin w_req.a = CTwo;   w_req.b = r_zeta; end        // t2
            6'd3:  begin w_req.a = r_t2;   w_req.b = r_wn; end
            6'd4:  begin w_req.a = r_t2;   w_req.b = r_acc; end
            6'd5:  begin w_req.op = OP_SUB; w_req.a = r_t1; w_req.b = r_t2; end
            6'd6:  begin w_req.a = r_t0;   w_req.b = r_spd; end         // t2
            6'd7:  begin w_req.op = OP_SUB; w_req.a = r_t1; w_req.b = r_t2; end
            6'd8:  begin w_req.a = r_t1;   w_req.b = r_dt; end
            6'd9:  begin w_req.op = OP_ADD; w_req.a = r_acc; w_req.b = r_t1; end
            6'd10: begin w_req.a = r_acc;  w_req.b = r_dt; end
            6'd11: begin w_req.op = OP_ADD; w_req.a = r_spd; w_req.b = r_t1; end
            6'd12: begin w_req.op = OP_SUB; w_req.a = r_spd; w_req.b = r_meas; end
            6'd13: begin w_req.op = OP_SUB; w_req.a = r_err; w_req.b = r_lerr; end
            6'd14: begin w_req.op = OP_DIV; w_req.a = r_t1; w_req.b = r_dt; end
            6'd15: begin w_req.a = CC1;    w_req.b = r_err; end         // t0
            6'd16: begin w_req.a = CC2;    w_req.b = r_dq; end          // t1
            6'd17: begin w_req.op = OP_ADD; w_req.a = r_t0; w_req.b = r_t1; end
            6'd18: begin w_req.op = OP_SUB; w_req.a = '0; w_req.b = r_gp; end
            6'd19: begin w_req.a = r_t1;   w_req.b = r_t2; end          // t1
            6'd20: begin w_req.a = r_t1;   w_req.b = r_err; end
            6'd21: begin w_req.a = r_t1;   w_req.b = r_dt; end
            6'd22: begin w_req.op = OP_ADD; w_req.a = r_kp; w_req.b = r_t1; end
            6'd23: begin w_req.a = r_err;  w_req.b = r_dt; end
            6'd24: begin w_req.op = OP_ADD; w_req.a = r_int; w_req.b = r_t1; end
            6'd25: begin w_req.op = OP_SUB; w_req.a = '0; w_req.b = r_gi; end
            6'd26: begin w_req.a = r_t1;   w_req.b = r_t2; end
            6'd27: begin w_req.a = r_t1;   w_req.b = r_int; end
            6'd28: begin w_req.op = OP_ADD; w_req.a = r_ki; w_req.b = r_t1; end
            6'd29: begin w_req.a = r_tau;  w_req.b = r_fd; end          // t0
            6'd30: begin w_req.a = r_dt;   w_req.b = r_dq; end          // t1
            6'd31: begin w_req.op = OP_ADD; w_req.a = r_t0; w_req.b = r_t1; end
            6'd32: begin w_req.op = OP_ADD; w_req.a = r_tau; w_req.b = r_dt; end
            6'd33: begin w_req.op = OP_DIV; w_req.a = r_t0; w_req.b = r_t1; end
            6'd34: begin w_req.op = OP_DIV; w_req.a = r_fd; w_req.b = r_dt; end
            6'd35: begin w_req.a = CC1;    w_req.b = r_err; end
            6'd36: begin w_req.a = CC2;    w_req.b = r_fq; end
            6'd37: begin w_req.op = OP_ADD; w_req.a = r_t0; w_req.b = r_t1; end
            6'd38: begin w_req.op = OP_SUB; w_req.a = '0; w_req.b = r_gd; end
            6'd39: begin w_req.a = r_t1;   w_req.b = r_t2; end
            6'd40: begin w_req.a = r_t1;   w_req.b = r_fq; end
            6'd41: begin w_req.a = r_t1;   w_req.b = r_dt; end
            6'd42: begin w_req.op = OP_ADD; w_req.a = r_kd; w_req.b = r_t1; end
            default: begin w_req.start = 1'b0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_RUN;
            S_RUN:  if (w_rsp.done && r_pc == PcW'(NumOps - 1)) n_state = S_WAIT;
            S_WAIT: if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_sp <= '0; r_wn <= COne; r_zeta <= COne;
            r_gp <= '0; r_gi <= '0; r_gd <= '0; r_tau <= '0;
            r_spd <= '0; r_acc <= '0; r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_int <= '0; r_lerr <= '0; r_fd <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SP:   r_sp   <= i_cfg_data;
                    REG_WN:   r_wn   <= {1'b0, i_cfg_data[30:0]};
                    REG_ZETA: r_zeta <= {1'b0, i_cfg_data[30:0]};
                    REG_GP:   r_gp   <= i_cfg_data;
                    REG_GI:   r_gi   <= i_cfg_data;
                    REG_GD:   r_gd   <= i_cfg_data;
                    REG_TAU:  r_tau  <= {1'b0, i_cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_meas   <= s_axis_tdata[31:0];
                // zero interval counts as one lsb
                r_dt     <= (s_axis_tdata[62:32] == '0) ? 32'sd1 : {1'b0, s_axis_tdata[62:32]};
                r_pc     <= '0;
                r_issued <= 1'b0;
            end
            if (r_state == S_RUN) begin
                if (w_req.start) r_issued <= 1'b1;
                if (w_rsp.done) begin
                    r_issued <= 1'b0;
                    r_pc <= r_pc + 1'b1;
                    unique case (r_pc)
                        6'd0:  r_t0 <= w_rsp.y;
                        6'd1, 6'd5, 6'd7, 6'd8, 6'd10, 6'd13, 6'd16, 6'd18, 6'd19,
                        6'd20, 6'd21, 6'd23, 6'd25, 6'd26, 6'd27, 6'd30, 6'd32,
                        6'd36, 6'd38, 6'd39, 6'd40, 6'd41: r_t1 <= w_rsp.y;
                        6'd2, 6'd3, 6'd4, 6'd6, 6'd17, 6'd37:
                            r_t2 <= w_rsp.y;
                        6'd9:  r_acc <= w_rsp.y;
                        6'd11: r_spd <= w_rsp.y;
                        6'd12: r_err <= w_rsp.y;
                        6'd14: r_dq  <= w_rsp.y;
                        6'd15, 6'd29, 6'd31, 6'd35: r_t0 <= w_rsp.y;
                        // kp clamped to 0..100
                        6'd22: r_kp <= w_rsp.y[DataWidth-1] ? '0 :
                                       ((w_rsp.y > CHund) ? CHund : w_rsp.y);
                        6'd24: r_int <= w_rsp.y;
                        6'd28: r_ki  <= w_rsp.y;
                        6'd33: r_fd  <= w_rsp.y;
                        6'd34: r_fq  <= w_rsp.y;
                        6'd42: begin
                            r_kd   <= (w_rsp.y > CFifty) ? CFifty : w_rsp.y;
                            r_lerr <= r_err;
                        end
                        default: ;
                    endcase
                end
            end
            // load a new result, or free the register once the old one is taken
            if (r_state == S_WAIT && n_state == S_IDLE) begin
                r_ovalid <= 1'b1;
                r_odata  <= {1'b0, r_kd, r_ki, r_kp[22:0], r_err, r_spd};
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_kp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_kp[DataWidth-1] && (r_kp <= CHund)) else $error("kp out of range");
    a_kd_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kd <= CFifty) else $error("kd above cap");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_ovalid && !m_axis_tready) |=> r_state == S_WAIT)
        else $error("result overrun");
endmodule

### design/apgt_alu.sv
module apgt_alu import apgt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);
    localparam int CntW = $clog2(DivSteps + 1);

    logic                  r_busy, n_busy;
    logic                  r_neg;
    logic [DataWidth-1:0]  r_dvs;
    logic [DivSteps-1:0]   r_num;
    logic [DataWidth:0]    r_rem;
    logic [DivSteps-1:0]   r_quo;
    logic [CntW-1:0]       r_cnt;
    logic                  r_done;
    t_word                 r_y;

    logic [DataWidth-1:0]  w_ma, w_mb;
    logic [2*DataWidth-1:0] w_prod;
    logic [2*DataWidth-FracBits-1:0] w_pmag;
    logic signed [DataWidth:0] w_sum;
    logic [DataWidth:0]    w_rsh, w_rsub;
    t_word                 w_res;
    logic                  w_big;

    function automatic t_word from_mag(input logic neg, input logic big,
                                       input logic [DataWidth-1:0] m);
        logic ovf;
        ovf = big || m[DataWidth-1];
        if (neg) from_mag = ovf ? VMin : -$signed(m);
        else     from_mag = ovf ? VMax : $signed(m);
    endfunction

    assign w_ma = i_req.a[DataWidth-1] ? DataWidth'(-i_req.a) : i_req.a;
    assign w_mb = i_req.b[DataWidth-1] ? DataWidth'(-i_req.b) : i_req.b;
    assign w_prod = w_ma * w_mb;
    assign w_pmag = w_prod[2*DataWidth-1:FracBits];
    assign w_rsh  = {r_rem[DataWidth-1:0], r_num[DivSteps-1]};
    assign w_rsub = w_rsh - {1'b0, r_dvs};

    always_comb begin
        w_sum = '0;
        w_res = '0;
        w_big = 1'b0;
        unique case (i_req.op)
            OP_ADD: w_sum = {i_req.a[DataWidth-1], i_req.a} + {i_req.b[DataWidth-1], i_req.b};
            OP_SUB: w_sum = {i_req.a[DataWidth-1], i_req.a} - {i_req.b[DataWidth-1], i_req.b};
            default: w_sum = '0;
        endcase
        if (w_sum[DataWidth] != w_sum[DataWidth-1])
            w_res = w_sum[DataWidth] ? VMin : VMax;
        else
            w_res = w_sum[DataWidth-1:0];
        if (i_req.op == OP_MUL) begin
            w_big = |w_pmag[2*DataWidth-FracBits-1:DataWidth];
            w_res = from_mag(i_req.a[DataWidth-1] ^ i_req.b[DataWidth-1], w_big,
                             w_pmag[DataWidth-1:0]);
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_req.start && i_req.op == OP_DIV && i_req.b != '0) n_busy = 1'b1;
        else if (r_busy && r_cnt == CntW'(DivSteps - 1)) n_busy = 1'b0;
    end

    // add, sub and mul results registered; divide one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.op != OP_DIV) begin
                    r_y    <= w_res;
                    r_done <= 1'b1;
                end else if (i_req.b == '0) begin
                    r_y    <= i_req.a[DataWidth-1] ? VMin : ((i_req.a == '0) ? '0 : VMax);
                    r_done <= 1'b1;
                end else begin
                    r_neg <= i_req.a[DataWidth-1] ^ i_req.b[DataWidth-1];
                    r_dvs <= w_mb;
                    r_num <= {w_ma, {FracBits{1'b0}}};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                end
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 1'b1;
                if (!w_rsub[DataWidth]) begin
                    r_rem <= w_rsub;
                    r_quo <= {r_quo[DivSteps-2:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_quo <= {r_quo[DivSteps-2:0], 1'b0};
                end
                if (r_cnt == CntW'(DivSteps - 1)) begin
                    r_done <= 1'b1;
                    r_y <= from_mag(r_neg,
                        (|r_quo[DivSteps-2:DataWidth-1]),
                        {r_quo[DataWidth-2:0], ~w_rsub[DataWidth]});
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.y    = r_y;
endmodule

### tb/adaptive_pid_gain_tuner_checker.sv
`timescale 1ns / 100ps
module adaptive_pid_gain_tuner_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [63:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [151:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    import apgt_pkg::*;

    typedef longint signed t_wide;

    localparam t_wide WMax = 64'sd2147483647;
    localparam t_wide WMin = -64'sd2147483648;

    t_wide sp, wn, zeta, gp, gi, gd, tau;
    t_wide spd, acc, kp, ki, kd, integ, last_e, fd;
    logic [151:0] tuner_results[$];

    function automatic t_wide sat(input logic signed [127:0] v);
        if (v > WMax) return WMax;
        if (v < WMin) return WMin;
        return t_wide'(v);
    endfunction

    function automatic t_wide qadd(input t_wide a, input t_wide b);
        return sat(128'(a) + 128'(b));
    endfunction

    function automatic t_wide qsub(input t_wide a, input t_wide b);
        return sat(128'(a) - 128'(b));
    endfunction

    // truncating toward zero, so shift the magnitude
    function automatic t_wide qmul(input t_wide a, input t_wide b);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(a) * 128'(b);
        m = p < 0 ? 128'(-p) : 128'(p);
        m = m >> FracBits;
        return sat(p < 0 ? -$signed(m) : $signed(m));
    endfunction

    function automatic t_wide qdiv(input t_wide a, input t_wide b);
        logic signed [127:0] n;
        if (b == 0) return a > 0 ? WMax : (a < 0 ? WMin : 0);
        n = 128'(a) <<< FracBits;
        return sat(n / 128'(b));
    endfunction

    task automatic predict_step(input logic [63:0] d);
        t_wide meas, dt, wn2, ain, e, dq, sens, fq;
        meas = t_wide'($signed(d[31:0]));
        dt = t_wide'(d[62:32]);
        if (dt == 0) dt = 1;
        wn2 = qmul(wn, wn);
        ain = qsub(qmul(wn2, sp), qmul(qmul(qmul(t_wide'(CTwo), zeta), wn), acc));
        ain = qsub(ain, qmul(wn2, spd));
        acc = qadd(acc, qmul(ain, dt));
        spd = qadd(spd, qmul(acc, dt));
        e = qsub(spd, meas);
        dq = qdiv(qsub(e, last_e), dt);
        sens = qadd(qmul(t_wide'(CC1), e), qmul(t_wide'(CC2), dq));
        kp = qadd(kp, qmul(qmul(qmul(qsub(0, gp), sens), e), dt));
        if (kp > t_wide'(CHund)) kp = t_wide'(CHund);
        if (kp < 0) kp = 0;
        integ = qadd(integ, qmul(e, dt));
        ki = qadd(ki, qmul(qmul(qsub(0, gi), sens), integ));
        fd = qdiv(qadd(qmul(tau, fd), qmul(dt, dq)), qadd(tau, dt));
        fq = qdiv(fd, dt);
        sens = qadd(qmul(t_wide'(CC1), e), qmul(t_wide'(CC2), fq));
        kd = qadd(kd, qmul(qmul(qmul(qsub(0, gd), sens), fq), dt));
        if (kd > t_wide'(CFifty)) kd = t_wide'(CFifty);
        last_e = e;
        tuner_results.push_back({1'b0, kd[31:0], ki[31:0], kp[22:0], e[31:0], spd[31:0]});
    endtask

    assign o_pending = tuner_results.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sp <= 0; wn <= t_wide'(COne); zeta <= t_wide'(COne);
            gp <= 0; gi <= 0; gd <= 0; tau <= 0;
            spd <= 0; acc <= 0; kp <= 0; ki <= 0; kd <= 0;
            integ <= 0; last_e <= 0; fd <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SP:   sp   = t_wide'($signed(i_cfg_data));
                    REG_WN:   wn   = t_wide'(i_cfg_data[30:0]);
                    REG_ZETA: zeta = t_wide'(i_cfg_data[30:0]);
                    REG_GP:   gp   = t_wide'($signed(i_cfg_data));
                    REG_GI:   gi   = t_wide'($signed(i_cfg_data));
                    REG_GD:   gd   = t_wide'($signed(i_cfg_data));
                    REG_TAU:  tau  = t_wide'(i_cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_step(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (tuner_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else if (tuner_results[0] !== i_out_data) begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             tuner_results[0], i_out_data);
                    o_fail_count <= o_fail_count + 1;
                    void'(tuner_results.pop_front());
                end else begin
                    void'(tuner_results.pop_front());
                end
            end
        end
    end
endmodule

### tb/adaptive_pid_gain_tuner_top_test.sv
`timescale 1ns / 100ps
module adaptive_pid_gain_tuner_top_test;
    import apgt_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           hold_sink = 1'b0;

    always #6 i_clk = ~i_clk;

    adaptive_pid_gain_tuner_top dut (.*);

    adaptive_pid_gain_tuner_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall before each result, long hold when asked
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            m_axis_tready <= 1'b0;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one measurement request, with a random gap unless told otherwise;
    // valid stays up after the request so back-to-back requests need no gap
    task automatic send_sample(input logic [31:0] speed, input logic [30:0] dt,
                               input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, dt, speed};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // small dt keeps the model from saturating at once
    function automatic logic [30:0] rand_interval;
        case ($urandom_range(0, 9))
            0: rand_interval = 31'($urandom);
            1: rand_interval = 31'($urandom_range(0, 4));
            default: rand_interval = 31'($urandom_range(1, 8192));
        endcase
    endfunction

    function automatic logic [31:0] rand_speed;
        if ($urandom_range(0, 4) == 0) rand_speed = $urandom;
        else rand_speed = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endfunction

    initial begin
        logic [31:0] cfg_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero interval, saturation
        send_sample(32'h0000_0000, 31'd1, 1'b0);
        send_sample(32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 31'd0, 1'b0);
        send_sample(32'hffff_ffff, 31'h0000_4000, 1'b0);
        drain_results();
        write_reg(REG_SP, 32'h7fff_ffff);
        write_reg(REG_WN, 32'h7fff_ffff);
        write_reg(REG_ZETA, 32'h0);
        write_reg(REG_GP, 32'h8000_0000);
        write_reg(REG_GI, 32'h7fff_ffff);
        write_reg(REG_GD, 32'h8000_0000);
        write_reg(REG_TAU, 32'h7fff_ffff);
        write_reg(3'd7, 32'hdead_beef);
        send_sample(32'h8000_0000, 31'h7fff_ffff, 1'b0);
        send_sample(32'h7fff_ffff, 31'd1, 1'b0);
        send_sample(32'h1234_5678, 31'h0001_0000, 1'b0);
        drain_results();
        write_reg(REG_SP, 32'h8000_0000);
        write_reg(REG_WN, 32'h0);
        write_reg(REG_ZETA, 32'hffff_ffff);
        write_reg(REG_GP, 32'h7fff_ffff);
        write_reg(REG_GD, 32'h7fff_ffff);
        write_reg(REG_TAU, 32'h0);
        send_sample(32'h0, 31'd0, 1'b0);
        send_sample(32'h5555_5555, 31'h2aaa_aaaa, 1'b0);
        send_sample(32'haaaa_aaaa, 31'h5555_5555, 1'b0);
        drain_results();

        // random phases with moderate and random settings
        for (int ph = 0; ph < 9; ph++) begin
            bit wild;
            wild = (ph % 3 == 2);
            cfg_val = wild ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000);
            write_reg(REG_SP, cfg_val);
            write_reg(REG_WN, wild ? $urandom : $urandom_range(0, 3 << 16));
            write_reg(REG_ZETA, wild ? $urandom : $urandom_range(0, 2 << 16));
            write_reg(REG_GP, wild ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000));
            write_reg(REG_GI, wild ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000));
            write_reg(REG_GD, wild ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000));
            write_reg(REG_TAU, wild ? $urandom : $urandom_range(0, 1 << 16));
            if (ph == 4) hold_sink = 1'b1;
            for (int n = 0; n < 100; n++) send_sample(rand_speed(), rand_interval(), ph == 4);
            // sender pauses until every result is back
            drain_results();
        end

        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
